[sv/pedec_pkg.sv]
// shared types, codes and lookup functions for the percent escape decoder
package pedec_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
        logic [1:0] end_status;
    } t_out;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // end status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDEF     = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    // escape phase codes
    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_PCT    = 2'd1;
    localparam logic [1:0] PH_HEX    = 2'd2;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [2:0] MATCH_LEN = 3'd6;
    localparam logic [2:0] MATCH_SAT = 3'd7;

    // "%UNDEF"
    function automatic logic [7:0] pat_undef(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h25;
            3'd1:    c = 8'h55;
            3'd2:    c = 8'h4E;
            3'd3:    c = 8'h44;
            3'd4:    c = 8'h45;
            3'd5:    c = 8'h46;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "%EMPTY"
    function automatic logic [7:0] pat_empty(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h25;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h4D;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h54;
            3'd5:    c = 8'h59;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            h.ok  = 1'b1;
            h.val = c[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

[sv/pedec_core.sv]
// per-byte decode: escape state, prefix match and result formation
module pedec_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  pedec_pkg::t_in    i_item,
    output pedec_pkg::t_out   o_result
);

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_nibble, n_nibble;
    logic       r_err, n_err;
    logic [2:0] r_pos, n_pos;
    logic       r_undef, n_undef;
    logic       r_empty, n_empty;

    logic            pos_live;
    logic            emit;
    logic [7:0]      val;
    pedec_pkg::t_hex hex;

    always_comb begin
        hex      = pedec_pkg::hex_value(i_item.in_byte);
        pos_live = r_pos < pedec_pkg::MATCH_LEN;

        // prefix matching
        if (pos_live) begin
            n_undef = r_undef && (i_item.in_byte == pedec_pkg::pat_undef(r_pos));
            n_empty = r_empty && (i_item.in_byte == pedec_pkg::pat_empty(r_pos));
            n_pos   = r_pos + 3'd1;
        end else begin
            n_undef = 1'b0;
            n_empty = 1'b0;
            n_pos   = pedec_pkg::MATCH_SAT;
        end

        emit     = 1'b0;
        val      = 8'h00;
        n_phase  = pedec_pkg::PH_NORMAL;
        n_nibble = r_nibble;
        n_err    = r_err;
        unique case (r_phase)
            pedec_pkg::PH_PCT: begin
                if (i_item.in_byte == pedec_pkg::CH_PCT) begin
                    emit = 1'b1;
                    val  = pedec_pkg::CH_PCT;
                end else if (i_item.in_byte == pedec_pkg::CH_LPAREN) begin
                    emit = 1'b1;
                    val  = pedec_pkg::CH_LBRACE;
                end else if (i_item.in_byte == pedec_pkg::CH_RPAREN) begin
                    emit = 1'b1;
                    val  = pedec_pkg::CH_RBRACE;
                end else if (hex.ok) begin
                    n_nibble = hex.val;
                    n_phase  = pedec_pkg::PH_HEX;
                end else begin
                    n_err = 1'b1;
                end
            end
            pedec_pkg::PH_HEX: begin
                if (hex.ok) begin
                    emit = 1'b1;
                    val  = {r_nibble, hex.val};
                end else begin
                    n_err = 1'b1;
                end
            end
            default: begin
                // unused phase code behaves as normal
                if (i_item.in_byte == pedec_pkg::CH_PLUS) begin
                    emit = 1'b1;
                    val  = pedec_pkg::CH_SPACE;
                end else if (i_item.in_byte == pedec_pkg::CH_PCT) begin
                    n_phase = pedec_pkg::PH_PCT;
                end else begin
                    emit = 1'b1;
                    val  = i_item.in_byte;
                end
            end
        endcase

        // silence data after an error or while a special prefix may still match
        emit = emit && !n_err && !n_undef && !n_empty;

        o_result.out_byte   = emit ? val : 8'h00;
        o_result.out_valid  = emit;
        o_result.out_last   = i_item.in_last;
        o_result.end_status = pedec_pkg::ST_OK;
        if (i_item.in_last) begin
            if (n_undef) begin
                o_result.end_status = pedec_pkg::ST_UNDEF;
            end else if (n_empty) begin
                o_result.end_status = pedec_pkg::ST_EMPTY;
            end else if (n_err || n_phase != pedec_pkg::PH_NORMAL) begin
                o_result.end_status = pedec_pkg::ST_MALFORMED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= pedec_pkg::PH_NORMAL;
            r_nibble <= 4'd0;
            r_err    <= 1'b0;
            r_pos    <= 3'd0;
            r_undef  <= 1'b1;
            r_empty  <= 1'b1;
        end else if (i_accept) begin
            if (i_item.in_last) begin
                // string done, start fresh
                r_phase  <= pedec_pkg::PH_NORMAL;
                r_nibble <= 4'd0;
                r_err    <= 1'b0;
                r_pos    <= 3'd0;
                r_undef  <= 1'b1;
                r_empty  <= 1'b1;
            end else begin
                r_phase  <= n_phase;
                r_nibble <= n_nibble;
                r_err    <= n_err;
                r_pos    <= n_pos;
                r_undef  <= n_undef;
                r_empty  <= n_empty;
            end
        end
    end

endmodule

[sv/pedec_skid.sv]
// two-entry output buffer that decouples input ready from output ready
module pedec_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pedec_pkg::t_out   i_data,
    output logic              o_ready,
    output logic              o_valid,
    output pedec_pkg::t_out   o_data,
    input  logic              i_ready
);

    logic            r_main_valid;
    logic            r_skid_valid;
    pedec_pkg::t_out r_main;
    pedec_pkg::t_out r_skid;
    logic            pop;

    assign pop     = r_main_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (!r_main_valid) begin
            r_main_valid <= i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_data;
            end
        end else if (!r_main_valid) begin
            if (i_push) begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

[sv/percent_escape_decoder.sv]
// percent escape decoder top level: decode logic feeding an output buffer
// a byte's result is decoded combinationally and registered in the output buffer on the byte's transfer
// throughput: 1 byte per cycle while the output buffer has room, set by the combinational decode step
// a 2-entry output buffer keeps input ready off the output ready path
// reset (synchronous, active low) clears decode state and empties the buffer
module percent_escape_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pedec_pkg::t_in    i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pedec_pkg::t_out   o_out
);

    logic            accept;
    pedec_pkg::t_out result;

    assign accept = i_in_valid && o_in_ready;

    pedec_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in),
        .o_result (result)
    );

    pedec_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (result),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out),
        .i_ready (i_out_ready)
    );

endmodule
